// ===== design/word_crc32_engine_macros.svh =====
// Assertion shorthands for the word CRC-32 engine.
// Each one samples on clk and stays quiet while rst_n is low.
`ifndef WORD_CRC32_ENGINE_MACROS_SVH
`define WORD_CRC32_ENGINE_MACROS_SVH

// Same-cycle implication.
`define WCRC32_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WCRC32_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wcrc32_pkg.sv =====
package wcrc32_pkg;

  localparam int unsigned CRC_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_STEPS = 32;

  typedef logic [CRC_W-1:0] crc_t;
  typedef crc_t fold_cols_t [CRC_W];

  localparam crc_t CRC_POLY = 32'hEDB8_8320;
  localparam crc_t CRC_INIT = 32'hFFFF_FFFF;

  // Control handed from the front register to the state update.
  typedef struct packed {
    logic adv;   // beat moves into the result register this cycle
    logic last;  // beat closes a block
  } upd_ctl_t;

  // Response of the 32-step fold to each single input bit.
  function automatic fold_cols_t gen_fold_cols();
    fold_cols_t cols;
    crc_t       v;
    for (int i = 0; i < CRC_W; i++) begin
      v = crc_t'(1) << i;
      for (int k = 0; k < CRC_STEPS; k++) begin
        v = (v >> 1) ^ (v[0] ? CRC_POLY : '0);
      end
      cols[i] = v;
    end
    return cols;
  endfunction

  localparam fold_cols_t FOLD_COLS = gen_fold_cols();

  // The fold is linear over GF(2): XOR together the columns of the set bits.
  function automatic crc_t crc_fold(crc_t v);
    crc_t acc;
    acc = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (v[i]) begin
        acc = acc ^ FOLD_COLS[i];
      end
    end
    return acc;
  endfunction

endpackage

// ===== design/wcrc32_in_if.sv =====
interface wcrc32_in_if;
  import wcrc32_pkg::*;

  logic valid;
  logic ready;
  crc_t data_word;
  logic last;

  modport source (output valid, output data_word, output last, input ready);
  modport sink   (input valid, input data_word, input last, output ready);
endinterface

// ===== design/wcrc32_out_if.sv =====
interface wcrc32_out_if;
  import wcrc32_pkg::*;

  logic valid;
  logic ready;
  crc_t crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== design/wcrc32_cfg_if.sv =====
interface wcrc32_cfg_if;
  logic valid;
  logic ready;
  logic byte_mode;

  modport source (output valid, output byte_mode, input ready);
  modport sink   (input valid, input byte_mode, output ready);
endinterface

// ===== design/wcrc32_state.sv =====
module wcrc32_state (
  input  logic                clk,
  input  logic                rst_n,
  input  wcrc32_pkg::upd_ctl_t ctl,
  input  wcrc32_pkg::crc_t    item,
  output wcrc32_pkg::crc_t    fold_val,
  output wcrc32_pkg::crc_t    running_crc
);
  import wcrc32_pkg::*;

  crc_t running_crc_r;
  crc_t running_crc_nxt;

  always_comb begin
    fold_val        = crc_fold(running_crc_r ^ item);
    running_crc_nxt = running_crc_r;
    if (ctl.adv) begin
      // restart the chain after a closing beat
      running_crc_nxt = ctl.last ? CRC_INIT : fold_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= CRC_INIT;
    end else begin
      running_crc_r <= running_crc_nxt;
    end
  end

  assign running_crc = running_crc_r;

endmodule

// ===== design/word_crc32_engine.sv =====
// Word-wise reflected CRC-32 engine (polynomial 0xEDB88320, seed all ones).
// Channels:
//   in_bus  : valid/ready beats carrying data_word (32 bits) and last.
//   out_bus : valid/ready beats carrying crc_value, one per input beat, in order.
//   cfg_bus : valid/ready writes of byte_mode; always ready. In byte mode only
//             the low 8 bits of data_word enter the CRC. Write it while idle.
// Each beat is folded into the running CRC and the inverted result is
// returned; a beat with last set restarts the running CRC for the next beat.
// Path: a beat accepted on in_bus is held in the front register, folded into
// the result register when that can take it, and shown on out_bus from there.
// Throughput: one beat per cycle while out_bus is not held. The front
// register and the result register form a two-entry pipeline; the CRC update
// is one XOR network between them, the running CRC fed back in the same cycle.
// Stall: while out_bus is held, the result register holds its beat and the
// front register still takes one more beat; in_bus ready drops after that.
// Reset (synchronous, rst_n low): both pipeline registers empty, running
// CRC back to all ones, byte_mode cleared to word mode.
`include "word_crc32_engine_macros.svh"

module word_crc32_engine (
  input  logic          clk,
  input  logic          rst_n,
  wcrc32_in_if.sink     in_bus,
  wcrc32_out_if.source  out_bus,
  wcrc32_cfg_if.sink    cfg_bus
);
  import wcrc32_pkg::*;

  // configuration
  logic     byte_mode_r;

  // front register: captured beat, already masked for byte mode
  logic     s1_vld_r;
  crc_t     s1_item_r;
  logic     s1_last_r;

  // result register
  logic     out_vld_r;
  crc_t     out_crc_r;

  logic     in_take;
  logic     adv;
  upd_ctl_t upd_ctl;
  crc_t     fold_val;
  crc_t     running_crc;
  crc_t     item_masked;

  // Advance the front beat when the result register is empty or draining.
  assign adv     = s1_vld_r && (!out_vld_r || out_bus.ready);
  assign in_take = in_bus.valid && in_bus.ready;

  assign in_bus.ready  = !s1_vld_r || adv;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid     = out_vld_r;
  assign out_bus.crc_value = out_crc_r;

  // Drop the upper 24 bits in byte mode.
  assign item_masked = byte_mode_r
                     ? {{(CRC_W-BYTE_W){1'b0}}, in_bus.data_word[BYTE_W-1:0]}
                     : in_bus.data_word;

  assign upd_ctl.adv  = adv;
  assign upd_ctl.last = s1_last_r;

  wcrc32_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (upd_ctl),
    .item        (s1_item_r),
    .fold_val    (fold_val),
    .running_crc (running_crc)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_r <= 1'b0;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      byte_mode_r <= cfg_bus.byte_mode;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload: hold unless a new beat arrives
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= item_masked;
      s1_last_r <= in_bus.last;
    end
    if (adv) begin
      out_crc_r <= ~fold_val;
    end
  end

  // A closing beat leaves the running CRC at its seed.
  `WCRC32_ASSERT_NEXT(a_last_reseeds, adv && s1_last_r, running_crc == CRC_INIT, "CRC not reseeded after last beat")
  // A non-closing beat leaves the result equal to the inverted running CRC.
  `WCRC32_ASSERT_NEXT(a_result_tracks, adv && !s1_last_r, out_crc_r == ~running_crc, "result does not match running CRC")
  // Both registers full and the sink stalled: the input must back off.
  `WCRC32_ASSERT_SAME(a_full_backpressure, s1_vld_r && out_vld_r && !out_bus.ready, !in_bus.ready, "input ready while pipeline full and stalled")
  // An advancing beat always lands in the result register.
  `WCRC32_ASSERT_NEXT(a_adv_fills_out, adv, out_vld_r, "advanced beat lost")

endmodule
